FILE: src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Types, constants and reciprocal factors shared by the 3x3 box smoothing
// block: item structs, line-buffer entry layout and divisor codes.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int MAX_DIM  = 512;
    localparam int MIN_DIM  = 2;
    localparam int CH_W     = 16;
    localparam int CFG_W    = 10;
    localparam logic [CFG_W-1:0] DIM_RESET = 10'd512;

    // A column of up to three rows, and a window of up to nine pixels.
    localparam int COL_W    = 18;
    localparam int SUM_W    = 20;

    // floor(s / n) = (s * RECIP_n) >> RECIP_SHIFT for every sum of up to
    // nine 16-bit channels.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_4 = 23'd4194304;
    localparam logic [RECIP_W-1:0] RECIP_6 = 23'd2796203;
    localparam logic [RECIP_W-1:0] RECIP_9 = 23'd1864136;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        DIV_4 = 2'd0,
        DIV_6 = 2'd1,
        DIV_9 = 2'd2
    } t_div;

    typedef struct packed {
        logic            opcode;
        logic [CH_W-1:0] pix_red;
        logic [CH_W-1:0] pix_green;
        logic [CH_W-1:0] pix_blue;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] avg_red;
        logic [CH_W-1:0] avg_green;
        logic [CH_W-1:0] avg_blue;
        logic            frame_last;
    } t_out_item;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // One line-buffer entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_line;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_colsum;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        t_div             div;
        logic             last;
    } t_sum;

    typedef struct packed {
        logic draining;
        logic priming;
    } t_status;

endpackage

FILE: src/box_smooth_3x3.sv
// ----------------------------------------------------------------------------
// box_smooth_3x3
// Streaming 3x3 box filter over a square RGB frame, results in raster order
// one row and one column behind the input, last row flushed by drain items.
// ----------------------------------------------------------------------------
// Path: window sums into the result queue, then the reciprocal divide into
// the output register. Throughput: one item per cycle while the output
// takes results; the last pixel of a row yields two results and holds off
// the next item until the second leaves the queue, and after the last
// pixel of a frame drains wait while two line-buffer entries are fetched.
// Reset: synchronous, active low; counters and handshakes clear, frame_dim
// returns to 512, the line buffer keeps its contents and is not cleared.
module box_smooth_3x3 #(
    parameter int MAX_DIM = bsm_pkg::MAX_DIM
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bsm_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  bsm_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bsm_pkg::t_out_item        o_out_item
);

    localparam int ADDR_W = $clog2(MAX_DIM);
    localparam int CMP_W  = (ADDR_W + 1 > bsm_pkg::CFG_W) ? ADDR_W + 1 : bsm_pkg::CFG_W;

    logic [bsm_pkg::CFG_W-1:0] r_frame_dim;
    logic [CMP_W-1:0]          dim_wide, dim_use;
    logic [ADDR_W-1:0]         dim_last;
    bsm_pkg::t_sum             sum_item;
    logic                      sum_valid, sum_ready;
    bsm_pkg::t_status          status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_dim <= bsm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            r_frame_dim <= i_cfg_wdata;
        end
    end

    // The dimension in use is saturated to the supported range.
    assign dim_wide = CMP_W'(r_frame_dim);

    always_comb begin
        if (dim_wide < CMP_W'(bsm_pkg::MIN_DIM)) begin
            dim_use = CMP_W'(bsm_pkg::MIN_DIM);
        end else if (dim_wide > CMP_W'(MAX_DIM)) begin
            dim_use = CMP_W'(MAX_DIM);
        end else begin
            dim_use = dim_wide;
        end
    end

    assign dim_last = ADDR_W'(dim_use - CMP_W'(1));

    bsm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_dim_last  (dim_last),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_sum_valid (sum_valid),
        .i_sum_ready (sum_ready),
        .o_sum       (sum_item),
        .o_status    (status)
    );

    bsm_divide u_divide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sum_valid (sum_valid),
        .o_sum_ready (sum_ready),
        .i_sum       (sum_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // No item may enter while the drain window is still being fetched.
    a_no_accept_priming: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.priming |-> !o_in_ready)
        else $error("item accepted while the drain window was being fetched");

    a_cfg_aborts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !status.draining)
        else $error("frame_dim write did not abort the pending last row");

    a_drain_starts_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(status.draining) |-> status.priming)
        else $error("last row pending without a line-buffer fetch");

endmodule

FILE: src/bsm_ram.sv
// ----------------------------------------------------------------------------
// bsm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bsm_front.sv
// ----------------------------------------------------------------------------
// bsm_front
// Frame position counters, line buffer, column-sum windows and the window
// sums of each item, held in a two-slot result queue.
// ----------------------------------------------------------------------------
module bsm_front #(
    parameter  int MAX_DIM = bsm_pkg::MAX_DIM,
    localparam int ADDR_W  = $clog2(MAX_DIM)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_dim_last,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bsm_pkg::t_in_item i_in_item,
    output logic              o_sum_valid,
    input  logic              i_sum_ready,
    output bsm_pkg::t_sum     o_sum,
    output bsm_pkg::t_status  o_status
);

    function automatic bsm_pkg::t_colsum col3(bsm_pkg::t_rgb a, bsm_pkg::t_rgb b,
                                              bsm_pkg::t_rgb c);
        bsm_pkg::t_colsum s;
        s.red   = bsm_pkg::COL_W'(a.red)   + bsm_pkg::COL_W'(b.red)
                + bsm_pkg::COL_W'(c.red);
        s.green = bsm_pkg::COL_W'(a.green) + bsm_pkg::COL_W'(b.green)
                + bsm_pkg::COL_W'(c.green);
        s.blue  = bsm_pkg::COL_W'(a.blue)  + bsm_pkg::COL_W'(b.blue)
                + bsm_pkg::COL_W'(c.blue);
        return s;
    endfunction

    function automatic bsm_pkg::t_sum sum3(bsm_pkg::t_colsum a, bsm_pkg::t_colsum b,
                                           bsm_pkg::t_colsum c, bsm_pkg::t_div dv,
                                           logic last);
        bsm_pkg::t_sum s;
        s.red   = bsm_pkg::SUM_W'(a.red)   + bsm_pkg::SUM_W'(b.red)
                + bsm_pkg::SUM_W'(c.red);
        s.green = bsm_pkg::SUM_W'(a.green) + bsm_pkg::SUM_W'(b.green)
                + bsm_pkg::SUM_W'(c.green);
        s.blue  = bsm_pkg::SUM_W'(a.blue)  + bsm_pkg::SUM_W'(b.blue)
                + bsm_pkg::SUM_W'(c.blue);
        s.div   = dv;
        s.last  = last;
        return s;
    endfunction

    logic [ADDR_W-1:0] r_in_row, r_in_col, r_drain_col;
    logic              r_draining;
    logic [1:0]        r_prime_cnt;

    bsm_pkg::t_colsum  r_win0, r_win1;
    bsm_pkg::t_colsum  r_dwin_prev, r_dwin_cur, r_dwin_next;

    bsm_pkg::t_sum     r_slot_a, r_slot_b;
    logic              r_slot_a_vld, r_slot_b_vld;

    bsm_pkg::t_line    rd_line, wr_line;
    logic [ADDR_W-1:0] rd_addr, next_col;
    bsm_pkg::t_rgb     cur_rgb, top_rgb;
    bsm_pkg::t_colsum  cur_col, drain_col_sum, win0_use, dprev_use, dnext_use;
    bsm_pkg::t_sum     res0, res1;
    logic [1:0]        res_cnt;
    bsm_pkg::t_div     div_a, div_b, div_d;

    logic priming, advance, in_ready, accept, is_drain, pix_acc, drn_acc;
    logic row_ok, col_ok, row_top, col_wide, row_end, frame_end;
    logic has_prev, has_next, drain_last;

    assign priming  = r_draining && (r_prime_cnt != 2'd0);
    assign advance  = r_slot_a_vld && i_sum_ready;
    assign in_ready = !priming && (!r_slot_a_vld || (advance && !r_slot_b_vld));
    assign accept   = i_in_valid && in_ready;
    assign is_drain = (i_in_item.opcode == bsm_pkg::OP_DRAIN);
    // A pixel while the last row is pending and a drain outside it are
    // consumed and have no effect.
    assign pix_acc  = accept && !is_drain && !r_draining;
    assign drn_acc  = accept && is_drain && r_draining;

    assign row_ok    = (r_in_row != '0);
    assign col_ok    = (r_in_col != '0);
    assign row_top   = (r_in_row > ADDR_W'(1));
    assign col_wide  = (r_in_col > ADDR_W'(1));
    assign row_end   = (r_in_col == i_dim_last);
    assign frame_end = row_end && (r_in_row == i_dim_last);
    assign next_col  = row_end ? '0 : r_in_col + ADDR_W'(1);

    assign has_prev   = (r_drain_col != '0);
    assign has_next   = (r_drain_col != i_dim_last);
    assign drain_last = !has_next;

    assign cur_rgb.red   = i_in_item.pix_red;
    assign cur_rgb.green = i_in_item.pix_green;
    assign cur_rgb.blue  = i_in_item.pix_blue;

    // The row two up only counts once the frame is past its second row.
    assign top_rgb       = row_top ? rd_line.older : '0;
    assign cur_col       = col3(top_rgb, rd_line.newer, cur_rgb);
    assign drain_col_sum = col3('0, rd_line.older, rd_line.newer);

    assign win0_use  = col_wide ? r_win0 : '0;
    assign dprev_use = has_prev ? r_dwin_prev : '0;
    assign dnext_use = has_next ? r_dwin_next : '0;

    always_comb begin
        if (row_top && col_wide) begin
            div_a = bsm_pkg::DIV_9;
        end else if (row_top || col_wide) begin
            div_a = bsm_pkg::DIV_6;
        end else begin
            div_a = bsm_pkg::DIV_4;
        end
        div_b = row_top ? bsm_pkg::DIV_6 : bsm_pkg::DIV_4;
        div_d = (has_prev && has_next) ? bsm_pkg::DIV_6 : bsm_pkg::DIV_4;
    end

    always_comb begin
        res0    = sum3(cur_col, r_win1, win0_use, div_a, 1'b0);
        res1    = sum3(cur_col, r_win1, '0, div_b, 1'b0);
        res_cnt = 2'd0;
        if (pix_acc && row_ok && col_ok) begin
            res_cnt = row_end ? 2'd2 : 2'd1;
        end else if (drn_acc) begin
            res0    = sum3(dprev_use, r_dwin_cur, dnext_use, div_d, drain_last);
            res_cnt = 2'd1;
        end
    end

    // The read port always looks one column ahead: the next pixel column in
    // the frame, or, once primed, two columns beyond the drain position.
    always_comb begin
        if (r_draining) begin
            case (r_prime_cnt)
                2'd2:    rd_addr = ADDR_W'(1);
                2'd1:    rd_addr = ADDR_W'(2);
                default: rd_addr = r_drain_col + (drn_acc ? ADDR_W'(3) : ADDR_W'(2));
            endcase
        end else begin
            rd_addr = pix_acc ? next_col : r_in_col;
        end
    end

    assign wr_line.older = rd_line.newer;
    assign wr_line.newer = cur_rgb;

    bsm_ram #(
        .WIDTH ($bits(bsm_pkg::t_line)),
        .DEPTH (MAX_DIM)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_in_col),
        .i_wdata (wr_line),
        .i_raddr (rd_addr),
        .o_rdata (rd_line)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_drain_col  <= '0;
            r_draining   <= 1'b0;
            r_prime_cnt  <= 2'd0;
            r_slot_a_vld <= 1'b0;
            r_slot_b_vld <= 1'b0;
        end else begin
            if (accept && (res_cnt != 2'd0)) begin
                r_slot_a_vld <= 1'b1;
                r_slot_b_vld <= (res_cnt == 2'd2);
            end else if (advance) begin
                r_slot_a_vld <= r_slot_b_vld;
                r_slot_b_vld <= 1'b0;
            end

            if (i_cfg_we) begin
                r_in_row    <= '0;
                r_in_col    <= '0;
                r_drain_col <= '0;
                r_draining  <= 1'b0;
                r_prime_cnt <= 2'd0;
            end else begin
                if (priming) begin
                    r_prime_cnt <= r_prime_cnt - 2'd1;
                end
                if (pix_acc) begin
                    r_in_col <= next_col;
                    if (frame_end) begin
                        // Fetch the first two line entries before any drain.
                        r_in_row    <= '0;
                        r_draining  <= 1'b1;
                        r_drain_col <= '0;
                        r_prime_cnt <= 2'd2;
                    end else if (row_end) begin
                        r_in_row <= r_in_row + ADDR_W'(1);
                    end
                end
                if (drn_acc) begin
                    if (drain_last) begin
                        r_in_row    <= '0;
                        r_in_col    <= '0;
                        r_drain_col <= '0;
                        r_draining  <= 1'b0;
                    end else begin
                        r_drain_col <= r_drain_col + ADDR_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_win0 <= r_win1;
            r_win1 <= cur_col;
        end
        if (priming || drn_acc) begin
            r_dwin_prev <= r_dwin_cur;
            r_dwin_cur  <= r_dwin_next;
            r_dwin_next <= drain_col_sum;
        end
        if (accept && (res_cnt != 2'd0)) begin
            r_slot_a <= res0;
            r_slot_b <= res1;
        end else if (advance) begin
            r_slot_a <= r_slot_b;
        end
    end

    assign o_in_ready       = in_ready;
    assign o_sum_valid      = r_slot_a_vld;
    assign o_sum            = r_slot_a;
    assign o_status.draining = r_draining;
    assign o_status.priming  = priming;

endmodule

FILE: src/bsm_divide.sv
// ----------------------------------------------------------------------------
// bsm_divide
// Turns window sums into truncated means by reciprocal multiplication and
// holds the finished item in the output register.
// ----------------------------------------------------------------------------
module bsm_divide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sum_valid,
    output logic               o_sum_ready,
    input  bsm_pkg::t_sum      i_sum,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsm_pkg::t_out_item o_out_item
);

    function automatic logic [bsm_pkg::CH_W-1:0] scale(
        logic [bsm_pkg::SUM_W-1:0]   s,
        logic [bsm_pkg::RECIP_W-1:0] m
    );
        logic [bsm_pkg::SUM_W+bsm_pkg::RECIP_W-1:0] p;
        p = s * m;
        return p[bsm_pkg::RECIP_SHIFT +: bsm_pkg::CH_W];
    endfunction

    logic                        r_out_vld;
    bsm_pkg::t_out_item          r_out_item, n_out_item;
    logic [bsm_pkg::RECIP_W-1:0] recip;
    logic                        take;

    always_comb begin
        unique case (i_sum.div)
            bsm_pkg::DIV_4: recip = bsm_pkg::RECIP_4;
            bsm_pkg::DIV_6: recip = bsm_pkg::RECIP_6;
            bsm_pkg::DIV_9: recip = bsm_pkg::RECIP_9;
            default:        recip = bsm_pkg::RECIP_4;
        endcase
    end

    always_comb begin
        n_out_item.avg_red    = scale(i_sum.red, recip);
        n_out_item.avg_green  = scale(i_sum.green, recip);
        n_out_item.avg_blue   = scale(i_sum.blue, recip);
        n_out_item.frame_last = i_sum.last;
    end

    assign o_sum_ready = !r_out_vld || i_out_ready;
    assign take        = i_sum_valid && o_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_sum_ready) begin
            r_out_vld <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule
